// ===== sv/aph_pkg.sv =====
// ----------------------------------------------------------------------------
// aph_pkg
// shared constants and register codes of the axis profile histogram
// ----------------------------------------------------------------------------
`default_nettype none

package aph_pkg;

  // default histogram geometry
  localparam int X_BINS_DEF = 2000;
  localparam int Y_BINS_DEF = 1000;
  localparam int BXW_DEF    = $clog2(X_BINS_DEF + 2);
  localparam int BYW_DEF    = $clog2(Y_BINS_DEF + 2);

  // register indexes on the configuration port
  localparam logic [2:0] REG_VERTEX_X = 3'd0;
  localparam logic [2:0] REG_VERTEX_Y = 3'd1;
  localparam logic [2:0] REG_VERTEX_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;

  localparam int CFG_IW = 3;
  localparam int CFG_DW = 17;

  // register reset values
  localparam logic signed [15:0] DIR_X_RST = 16'sd16384;

  // fixed point binning constants, projection in 2^-18 cm
  localparam logic signed [36:0] X_OFF  = 37'sd2621440;
  localparam logic signed [36:0] X_SPAN = 37'sd52428800;
  localparam int                 X_SHIFT = 20;   // X_SPAN = 50 * 2^20
  // radius in 1/256 cm
  localparam logic [23:0]        Y_SPAN  = 24'd25600;
  localparam int                 Y_SHIFT = 10;   // Y_SPAN = 25 * 2^10

  // reciprocals of 50 and 25 rounded up, scaled by 2^24, exact over the bin range
  localparam int RCP_SHIFT = 24;
  localparam int X_RCP     = 335545;
  localparam int Y_RCP     = 671089;

  // datapath widths
  localparam int MW  = 27;   // multiplier operand
  localparam int PW  = 54;   // multiplier product
  localparam int SW  = 48;   // sum of squares
  localparam int RTW = 24;   // square root
  localparam int DW  = 25;   // divider operands and quotient
  localparam int CW  = 32;   // bin count
  localparam int WW  = 48;   // bin weight sum

  localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
  localparam logic [WW-1:0] WSUM_MAX = {WW{1'b1}};
  localparam logic [DW-1:0] W_ONE    = DW'(1 << 16);
  localparam logic [DW-1:0] W_NUM    = DW'(1 << 24);

  localparam logic signed [18:0] PROJ_MAX = 19'sd262143;
  localparam logic signed [18:0] PROJ_MIN = -19'sd262144;
  localparam logic [17:0]        RAD_MAX  = 18'd262143;

endpackage

`default_nettype wire

// ===== sv/aph_if.sv =====
// ----------------------------------------------------------------------------
// aph_in_if / aph_out_if
// request and result channels of the axis profile histogram
// ----------------------------------------------------------------------------
`default_nettype none

interface aph_in_if #(
  parameter int BXW = aph_pkg::BXW_DEF,
  parameter int BYW = aph_pkg::BYW_DEF
);
  logic                valid;
  logic                ready;
  logic                command;
  logic signed [16:0]  hit_x;
  logic signed [16:0]  hit_y;
  logic signed [16:0]  hit_z;
  logic [BXW-1:0]      read_bin_x;
  logic [BYW-1:0]      read_bin_y;

  modport source (output valid, command, hit_x, hit_y, hit_z, read_bin_x, read_bin_y,
                  input ready);
  modport sink   (input valid, command, hit_x, hit_y, hit_z, read_bin_x, read_bin_y,
                  output ready);
endinterface

interface aph_out_if #(
  parameter int BXW = aph_pkg::BXW_DEF,
  parameter int BYW = aph_pkg::BYW_DEF
);
  logic                valid;
  logic                ready;
  logic signed [18:0]  projection;
  logic [17:0]         radius;
  logic [BXW-1:0]      bin_x;
  logic [BYW-1:0]      bin_y;
  logic [31:0]         bin_count;
  logic [47:0]         bin_weight_sum;

  modport source (output valid, projection, radius, bin_x, bin_y, bin_count,
                  bin_weight_sum, input ready);
  modport sink   (input valid, projection, radius, bin_x, bin_y, bin_count,
                  bin_weight_sum, output ready);
endinterface

`default_nettype wire

// ===== sv/aph_sqrt.sv =====
// ----------------------------------------------------------------------------
// aph_sqrt
// iterative integer square root, one root bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aph_sqrt (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [aph_pkg::SW-1:0]  radicand,
  output logic                         done,
  output logic [aph_pkg::RTW-1:0]      root
);
  localparam int RW = aph_pkg::RTW + 3;
  localparam int CNW = $clog2(aph_pkg::RTW + 1);

  logic [aph_pkg::SW-1:0]  rad_r, rad_nxt;
  logic [RW-1:0]           rem_r, rem_nxt;
  logic [aph_pkg::RTW-1:0] root_r, root_nxt;
  logic [CNW-1:0]          cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;
  logic [RW-1:0]           rem_sh;
  logic [RW-1:0]           trial;

  // shift in two radicand bits and try the next root bit
  always_comb begin
    rem_sh   = {rem_r[RW-3:0], rad_r[aph_pkg::SW-1 -: 2]};
    trial    = {1'b0, root_r, 2'b01};
    rad_nxt  = rad_r;
    rem_nxt  = rem_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rad_nxt  = radicand;
      rem_nxt  = '0;
      root_nxt = '0;
      cnt_nxt  = CNW'(aph_pkg::RTW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rad_nxt = {rad_r[aph_pkg::SW-3:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_nxt  = rem_sh - trial;
        root_nxt = {root_r[aph_pkg::RTW-2:0], 1'b1};
      end else begin
        rem_nxt  = rem_sh;
        root_nxt = {root_r[aph_pkg::RTW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rad_r  <= rad_nxt;
    rem_r  <= rem_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule

`default_nettype wire

// ===== sv/aph_div.sv =====
// ----------------------------------------------------------------------------
// aph_div
// restoring unsigned divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module aph_div (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  input  wire logic [aph_pkg::DW-1:0]  dividend,
  input  wire logic [aph_pkg::DW-1:0]  divisor,
  output logic                         done,
  output logic [aph_pkg::DW-1:0]       quotient
);
  localparam int CNW = $clog2(aph_pkg::DW + 1);

  logic [aph_pkg::DW-1:0] quo_r, quo_nxt;
  logic [aph_pkg::DW-1:0] dvs_r, dvs_nxt;
  logic [aph_pkg::DW:0]   rem_r, rem_nxt;
  logic [aph_pkg::DW:0]   rem_sh;
  logic [CNW-1:0]         cnt_r, cnt_nxt;
  logic                   busy_r, busy_nxt;
  logic                   done_r, done_nxt;

  // quotient register doubles as the dividend shifter
  always_comb begin
    rem_sh   = {rem_r[aph_pkg::DW-1:0], quo_r[aph_pkg::DW-1]};
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = CNW'(aph_pkg::DW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_sh >= {1'b0, dvs_r}) begin
        rem_nxt = rem_sh - {1'b0, dvs_r};
        quo_nxt = {quo_r[aph_pkg::DW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh;
        quo_nxt = {quo_r[aph_pkg::DW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== sv/aph_store.sv =====
// ----------------------------------------------------------------------------
// aph_store
// count and weight memories with a clearing pass after reset
// ----------------------------------------------------------------------------
`default_nettype none

module aph_store #(
  parameter int DEPTH = (aph_pkg::X_BINS_DEF + 2) * (aph_pkg::Y_BINS_DEF + 2),
  parameter int IW    = $clog2(DEPTH)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  output logic                        clear_done,
  input  wire logic                   rd_en,
  input  wire logic [IW-1:0]          rd_addr,
  output logic [aph_pkg::CW-1:0]      rd_count,
  output logic [aph_pkg::WW-1:0]      rd_weight,
  input  wire logic                   wr_en,
  input  wire logic [IW-1:0]          wr_addr,
  input  wire logic [aph_pkg::CW-1:0] wr_count,
  input  wire logic [aph_pkg::WW-1:0] wr_weight
);
  logic [aph_pkg::CW-1:0] cnt_mem [DEPTH];
  logic [aph_pkg::WW-1:0] wgt_mem [DEPTH];

  logic [IW-1:0]          clr_addr_r, clr_addr_nxt;
  logic                   clr_busy_r, clr_busy_nxt;
  logic                   we;
  logic [IW-1:0]          waddr;
  logic [aph_pkg::CW-1:0] wcnt;
  logic [aph_pkg::WW-1:0] wwgt;
  logic [aph_pkg::CW-1:0] rd_count_r;
  logic [aph_pkg::WW-1:0] rd_weight_r;

  // clearing sweep, one entry a cycle
  always_comb begin
    clr_addr_nxt = clr_addr_r;
    clr_busy_nxt = clr_busy_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
      if (clr_addr_r == IW'(DEPTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      clr_busy_r <= 1'b1;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      clr_busy_r <= clr_busy_nxt;
    end
  end

  // write port shared by the sweep and the update
  always_comb begin
    we    = clr_busy_r || wr_en;
    waddr = clr_busy_r ? clr_addr_r : wr_addr;
    wcnt  = clr_busy_r ? '0 : wr_count;
    wwgt  = clr_busy_r ? '0 : wr_weight;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      cnt_mem[waddr] <= wcnt;
      wgt_mem[waddr] <= wwgt;
    end
  end

  // registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_count_r  <= cnt_mem[rd_addr];
      rd_weight_r <= wgt_mem[rd_addr];
    end
  end

  assign rd_count   = rd_count_r;
  assign rd_weight  = rd_weight_r;
  assign clear_done = !clr_busy_r;

endmodule

`default_nettype wire

// ===== sv/axis_profile_histogram.sv =====
// ----------------------------------------------------------------------------
// axis_profile_histogram
// hit profile along a shower axis, binned into count and weight histograms
// ----------------------------------------------------------------------------
// After reset the block sweeps both bin memories to zero, one bin a cycle,
// over all (X_BINS+2)*(Y_BINS+2) bins (2006004 at the defaults), and takes no
// request until that is done; configuration writes are taken at any time. A
// fill request then passes the shared 27x27 multiplier for the dot and cross
// products and squares, the square root, four scaling and reciprocal products
// for the two bin indexes, the weight division (skipped at zero radius), an
// index product and a read-modify-write of the bin memories. One request is
// in work at a time; the result register lets the next request enter while a
// result waits to be taken.
`default_nettype none

module axis_profile_histogram #(
  parameter int X_BINS = aph_pkg::X_BINS_DEF,
  parameter int Y_BINS = aph_pkg::Y_BINS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         cfg_we,
  input  wire logic [aph_pkg::CFG_IW-1:0]   cfg_index,
  input  wire logic [aph_pkg::CFG_DW-1:0]   cfg_wdata,
  aph_in_if.sink                            in_ch,
  aph_out_if.source                         out_ch
);
  localparam int NBY   = Y_BINS + 2;
  localparam int DEPTH = (X_BINS + 2) * NBY;
  localparam int IW    = $clog2(DEPTH);
  localparam int BXW   = $clog2(X_BINS + 2);
  localparam int BYW   = $clog2(Y_BINS + 2);
  localparam int MW    = aph_pkg::MW;
  localparam int PW    = aph_pkg::PW;
  localparam int DW    = aph_pkg::DW;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MAC  = 4'd1;
  localparam logic [3:0] ST_SQRT = 4'd2;
  localparam logic [3:0] ST_MX   = 4'd3;
  localparam logic [3:0] ST_MY   = 4'd4;
  localparam logic [3:0] ST_DX   = 4'd5;
  localparam logic [3:0] ST_DY   = 4'd6;
  localparam logic [3:0] ST_DW   = 4'd7;
  localparam logic [3:0] ST_IDX  = 4'd8;
  localparam logic [3:0] ST_RD   = 4'd9;
  localparam logic [3:0] ST_RW   = 4'd10;

  // magnitude of a cross component, truncated by 10 bits
  function automatic logic [22:0] cmag(input logic signed [35:0] c);
    logic [35:0] a;
    a = c[35] ? 36'(-c) : 36'(c);
    return a[32:10];
  endfunction

  // configuration registers
  logic signed [16:0] vtx_r [3];
  logic signed [15:0] dir_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vtx_r[0] <= '0;
      vtx_r[1] <= '0;
      vtx_r[2] <= '0;
      dir_r[0] <= aph_pkg::DIR_X_RST;
      dir_r[1] <= '0;
      dir_r[2] <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aph_pkg::REG_VERTEX_X: vtx_r[0] <= cfg_wdata;
        aph_pkg::REG_VERTEX_Y: vtx_r[1] <= cfg_wdata;
        aph_pkg::REG_VERTEX_Z: vtx_r[2] <= cfg_wdata;
        aph_pkg::REG_DIR_X:    dir_r[0] <= cfg_wdata[15:0];
        aph_pkg::REG_DIR_Y:    dir_r[1] <= cfg_wdata[15:0];
        aph_pkg::REG_DIR_Z:    dir_r[2] <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // control and datapath registers
  logic [3:0]               state_r, state_nxt;
  logic [3:0]               step_r, step_nxt;
  logic                     run_r, run_nxt;
  logic                     rdcmd_r, rdcmd_nxt;
  logic signed [17:0]       d_r [3];
  logic signed [17:0]       d_nxt [3];
  logic signed [35:0]       p_r, p_nxt;
  logic signed [35:0]       c_r [3];
  logic signed [35:0]       c_nxt [3];
  logic [aph_pkg::SW-1:0]   s_r, s_nxt;
  logic [aph_pkg::RTW-1:0]  r_r, r_nxt;
  logic [DW-1:0]            qx_r, qx_nxt;
  logic [DW-1:0]            qy_r, qy_nxt;
  logic [DW-1:0]            w_r, w_nxt;
  logic [BXW-1:0]           bx_r, bx_nxt;
  logic [BYW-1:0]           by_r, by_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;
  logic signed [PW-1:0]     prod_r;

  logic                     out_valid_r, out_valid_nxt;
  logic signed [18:0]       o_proj_r, o_proj_nxt;
  logic [17:0]              o_rad_r, o_rad_nxt;
  logic [BXW-1:0]           o_bx_r, o_bx_nxt;
  logic [BYW-1:0]           o_by_r, o_by_nxt;
  logic [aph_pkg::CW-1:0]   o_cnt_r, o_cnt_nxt;
  logic [aph_pkg::WW-1:0]   o_wgt_r, o_wgt_nxt;

  // shared multiplier operands
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [MW-1:0]     dx_e [3];
  logic signed [MW-1:0]     ax_e [3];
  logic signed [MW-1:0]     cm_e [3];

  // unit handshakes
  logic                     sq_start, sq_done;
  logic [aph_pkg::RTW-1:0]  sq_root;
  logic                     dv_start, dv_done;
  logic [DW-1:0]            dv_num, dv_den, dv_quo;
  logic                     st_ready;
  logic                     rd_en, wr_en;
  logic [IW-1:0]            rd_addr;
  logic [aph_pkg::CW-1:0]   rd_count, wr_count;
  logic [aph_pkg::WW-1:0]   rd_weight, wr_weight;

  // binning helpers
  logic signed [36:0]       xs;
  logic                     x_under, x_over;
  logic signed [21:0]       pfl;
  logic [19:0]              rsh;
  logic [aph_pkg::WW:0]     wsum;
  logic                     in_acc, out_acc;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx_e[i] = MW'(d_r[i]);
      ax_e[i] = MW'(dir_r[i]);
      cm_e[i] = MW'(signed'({1'b0, cmag(c_r[i])}));
    end
  end

  assign xs      = 37'(p_r) + aph_pkg::X_OFF;
  assign x_under = xs[36];
  assign x_over  = !xs[36] && (xs >= aph_pkg::X_SPAN);

  // operand selection for the shared multiplier
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_MAC: begin
        case (step_r)
          4'd0:  begin mul_a = dx_e[0]; mul_b = ax_e[0]; end
          4'd1:  begin mul_a = dx_e[1]; mul_b = ax_e[1]; end
          4'd2:  begin mul_a = dx_e[2]; mul_b = ax_e[2]; end
          4'd3:  begin mul_a = dx_e[1]; mul_b = ax_e[2]; end
          4'd4:  begin mul_a = dx_e[2]; mul_b = ax_e[1]; end
          4'd5:  begin mul_a = dx_e[2]; mul_b = ax_e[0]; end
          4'd6:  begin mul_a = dx_e[0]; mul_b = ax_e[2]; end
          4'd7:  begin mul_a = dx_e[0]; mul_b = ax_e[1]; end
          4'd8:  begin mul_a = dx_e[1]; mul_b = ax_e[0]; end
          4'd9:  begin mul_a = cm_e[0]; mul_b = cm_e[0]; end
          4'd10: begin mul_a = cm_e[1]; mul_b = cm_e[1]; end
          4'd11: begin mul_a = cm_e[2]; mul_b = cm_e[2]; end
          default: ;
        endcase
      end
      ST_MX: begin
        mul_a = signed'({1'b0, xs[MW-2:0]});
        mul_b = MW'(X_BINS);
      end
      ST_MY: begin
        mul_a = signed'(MW'(r_r));
        mul_b = MW'(Y_BINS);
      end
      ST_DX: begin
        mul_a = signed'(MW'(qx_r));
        mul_b = MW'(aph_pkg::X_RCP);
      end
      ST_DY: begin
        mul_a = signed'(MW'(qy_r));
        mul_b = MW'(aph_pkg::Y_RCP);
      end
      ST_IDX: begin
        mul_a = signed'(MW'(bx_r));
        mul_b = MW'(NBY);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // divider computes the weight only
  assign dv_num   = aph_pkg::W_NUM;
  assign dv_den   = DW'(r_r);
  assign sq_start = (state_r == ST_SQRT) && !run_r;
  assign dv_start = (state_r == ST_DW) && (r_r != '0) && !run_r;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_valid_r && out_ch.ready;
  assign rd_en   = (state_r == ST_RD);
  assign rd_addr = prod_r[IW-1:0] + IW'(by_r);

  // clamped result fields
  assign pfl  = p_r[35:14];
  assign rsh  = r_r[aph_pkg::RTW-1:4];
  assign wsum = {1'b0, rd_weight} + (aph_pkg::WW+1)'(w_r);

  always_comb begin
    wr_count  = (rd_count == aph_pkg::CNT_MAX) ? rd_count : rd_count + 1'b1;
    wr_weight = wsum[aph_pkg::WW] ? aph_pkg::WSUM_MAX : wsum[aph_pkg::WW-1:0];
    wr_en     = (state_r == ST_RW) && (!out_valid_r || out_ch.ready) && !rdcmd_r;
  end

  // request sequencer
  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    run_nxt       = run_r;
    rdcmd_nxt     = rdcmd_r;
    d_nxt         = d_r;
    p_nxt         = p_r;
    c_nxt         = c_r;
    s_nxt         = s_r;
    r_nxt         = r_r;
    qx_nxt        = qx_r;
    qy_nxt        = qy_r;
    w_nxt         = w_r;
    bx_nxt        = bx_r;
    by_nxt        = by_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    o_proj_nxt    = o_proj_r;
    o_rad_nxt     = o_rad_r;
    o_bx_nxt      = o_bx_r;
    o_by_nxt      = o_by_r;
    o_cnt_nxt     = o_cnt_r;
    o_wgt_nxt     = o_wgt_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          rdcmd_nxt = in_ch.command;
          if (in_ch.command) begin
            bx_nxt    = (in_ch.read_bin_x > BXW'(X_BINS + 1)) ? BXW'(X_BINS + 1)
                                                             : in_ch.read_bin_x;
            by_nxt    = (in_ch.read_bin_y > BYW'(Y_BINS + 1)) ? BYW'(Y_BINS + 1)
                                                             : in_ch.read_bin_y;
            state_nxt = ST_IDX;
          end else begin
            d_nxt[0]  = 18'(in_ch.hit_x) - 18'(vtx_r[0]);
            d_nxt[1]  = 18'(in_ch.hit_y) - 18'(vtx_r[1]);
            d_nxt[2]  = 18'(in_ch.hit_z) - 18'(vtx_r[2]);
            p_nxt     = '0;
            c_nxt[0]  = '0;
            c_nxt[1]  = '0;
            c_nxt[2]  = '0;
            s_nxt     = '0;
            step_nxt  = '0;
            state_nxt = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        // fold in the product issued last cycle
        case (step_r)
          4'd1, 4'd2, 4'd3: p_nxt    = p_r + prod_r[35:0];
          4'd4:             c_nxt[0] = c_r[0] + prod_r[35:0];
          4'd5:             c_nxt[0] = c_r[0] - prod_r[35:0];
          4'd6:             c_nxt[1] = c_r[1] + prod_r[35:0];
          4'd7:             c_nxt[1] = c_r[1] - prod_r[35:0];
          4'd8:             c_nxt[2] = c_r[2] + prod_r[35:0];
          4'd9:             c_nxt[2] = c_r[2] - prod_r[35:0];
          4'd10, 4'd11, 4'd12:
            s_nxt = s_r + prod_r[aph_pkg::SW-1:0];
          default: ;
        endcase
        step_nxt = step_r + 1'b1;
        if (step_r == 4'd12) begin
          run_nxt   = 1'b0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        run_nxt = 1'b1;
        if (run_r && sq_done) begin
          r_nxt     = sq_root;
          run_nxt   = 1'b0;
          state_nxt = ST_MX;
        end
      end
      ST_MX: begin
        state_nxt = ST_MY;
      end
      ST_MY: begin
        qx_nxt    = prod_r[aph_pkg::X_SHIFT+DW-1:aph_pkg::X_SHIFT];
        state_nxt = ST_DX;
      end
      ST_DX: begin
        qy_nxt    = prod_r[aph_pkg::Y_SHIFT+DW-1:aph_pkg::Y_SHIFT];
        state_nxt = ST_DY;
      end
      ST_DY: begin
        // projection bin from the reciprocal product
        if (x_under) begin
          bx_nxt = '0;
        end else if (x_over) begin
          bx_nxt = BXW'(X_BINS + 1);
        end else begin
          bx_nxt = BXW'(prod_r[aph_pkg::RCP_SHIFT +: BXW]) + 1'b1;
        end
        state_nxt = ST_DW;
      end
      ST_DW: begin
        // radius bin on the first cycle, while its product is in place
        if (!run_r) begin
          by_nxt = (r_r >= aph_pkg::Y_SPAN) ? BYW'(Y_BINS + 1)
                                            : BYW'(prod_r[aph_pkg::RCP_SHIFT +: BYW]) + 1'b1;
        end
        if (r_r == '0) begin
          // zero radius takes unit weight
          w_nxt     = aph_pkg::W_ONE;
          state_nxt = ST_IDX;
        end else begin
          run_nxt = 1'b1;
          if (run_r && dv_done) begin
            w_nxt     = dv_quo;
            run_nxt   = 1'b0;
            state_nxt = ST_IDX;
          end
        end
      end
      ST_IDX: begin
        state_nxt = ST_RD;
      end
      ST_RD: begin
        idx_nxt   = rd_addr;
        state_nxt = ST_RW;
      end
      ST_RW: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          o_bx_nxt      = bx_r;
          o_by_nxt      = by_r;
          if (rdcmd_r) begin
            o_proj_nxt = '0;
            o_rad_nxt  = '0;
            o_cnt_nxt  = rd_count;
            o_wgt_nxt  = rd_weight;
          end else begin
            if (pfl > 22'(aph_pkg::PROJ_MAX)) begin
              o_proj_nxt = aph_pkg::PROJ_MAX;
            end else if (pfl < 22'(aph_pkg::PROJ_MIN)) begin
              o_proj_nxt = aph_pkg::PROJ_MIN;
            end else begin
              o_proj_nxt = pfl[18:0];
            end
            o_rad_nxt = (rsh > 20'(aph_pkg::RAD_MAX)) ? aph_pkg::RAD_MAX : rsh[17:0];
            o_cnt_nxt = wr_count;
            o_wgt_nxt = wr_weight;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      run_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      run_r       <= run_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rdcmd_r  <= rdcmd_nxt;
    d_r      <= d_nxt;
    p_r      <= p_nxt;
    c_r      <= c_nxt;
    s_r      <= s_nxt;
    r_r      <= r_nxt;
    qx_r     <= qx_nxt;
    qy_r     <= qy_nxt;
    w_r      <= w_nxt;
    bx_r     <= bx_nxt;
    by_r     <= by_nxt;
    idx_r    <= idx_nxt;
    o_proj_r <= o_proj_nxt;
    o_rad_r  <= o_rad_nxt;
    o_bx_r   <= o_bx_nxt;
    o_by_r   <= o_by_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_wgt_r  <= o_wgt_nxt;
  end

  // arithmetic units and bin memories
  aph_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (s_r),
    .done     (sq_done),
    .root     (sq_root)
  );

  aph_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (dv_start),
    .dividend (dv_num),
    .divisor  (dv_den),
    .done     (dv_done),
    .quotient (dv_quo)
  );

  aph_store #(
    .DEPTH (DEPTH),
    .IW    (IW)
  ) u_store (
    .clk        (clk),
    .rst_n      (rst_n),
    .clear_done (st_ready),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_count   (rd_count),
    .rd_weight  (rd_weight),
    .wr_en      (wr_en),
    .wr_addr    (idx_r),
    .wr_count   (wr_count),
    .wr_weight  (wr_weight)
  );

  // channel ports
  assign in_ch.ready           = st_ready && (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.projection     = o_proj_r;
  assign out_ch.radius         = o_rad_r;
  assign out_ch.bin_x          = o_bx_r;
  assign out_ch.bin_y          = o_by_r;
  assign out_ch.bin_count      = o_cnt_r;
  assign out_ch.bin_weight_sum = o_wgt_r;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for axis_profile_histogram. A predictor keeps its own
// register copy and sparse count and weight histograms. For every accepted
// fill or read request it works out the expected projection, radius, bin and
// bin contents. A checker compares each result, in order, against the oldest
// expected one. Directed tests cover the field extremes, underflow and
// overflow bins, clamping and reads past overflow. Random traffic follows
// under several axis settings, with random gaps and back-pressure.
// ----------------------------------------------------------------------------

module tb_top;
  import aph_pkg::*;

  localparam int NBY = Y_BINS_DEF + 2;

  typedef struct {
    bit                 cmd;
    logic signed [16:0] hx, hy, hz;
    logic [10:0]        rbx;
    logic [9:0]         rby;
  } hit_req_t;

  typedef struct {
    logic signed [18:0] proj;
    logic [17:0]        rad;
    logic [10:0]        bx;
    logic [9:0]         by;
    logic [31:0]        cnt;
    logic [47:0]        wsum;
  } bin_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IW-1:0] cfg_index = '0;
  logic [CFG_DW-1:0] cfg_wdata = '0;

  aph_in_if  in_ch ();
  aph_out_if out_ch ();

  axis_profile_histogram dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata), .in_ch(in_ch), .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  // predictor state
  longint            axis_reg [6];
  int unsigned       count_hist [int];
  longint unsigned   weight_hist [int];
  bin_result_t       pending_q [$];
  int                err_cnt = 0;
  int                hold_cycles = 0;
  int                rx_stall = 0;
  bit                calm = 1'b0;
  logic [10:0]       last_bx = '0;
  logic [9:0]        last_by = '0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.command = 1'b0;
    in_ch.hit_x = '0;
    in_ch.hit_y = '0;
    in_ch.hit_z = '0;
    in_ch.read_bin_x = '0;
    in_ch.read_bin_y = '0;
    out_ch.ready = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned s);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > s) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (s >= res + bitv) begin
        s = s - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic longint abs_trunc10(longint c);
    return ((c < 0) ? -c : c) >> 10;
  endfunction

  // histogram update and expected result of one request
  function automatic bin_result_t predict_bin(hit_req_t r);
    bin_result_t e;
    longint d[3], a[3], c[3], p, xs, pr, bx, by;
    longint unsigned cx, cy, cz, rr, w, ws;
    int idx;
    e.proj = '0;
    e.rad = '0;
    if (r.cmd) begin
      bx = (r.rbx > X_BINS_DEF + 1) ? X_BINS_DEF + 1 : r.rbx;
      by = (r.rby > Y_BINS_DEF + 1) ? Y_BINS_DEF + 1 : r.rby;
      idx = int'(bx * NBY + by);
    end else begin
      d[0] = longint'(r.hx) - axis_reg[0];
      d[1] = longint'(r.hy) - axis_reg[1];
      d[2] = longint'(r.hz) - axis_reg[2];
      for (int i = 0; i < 3; i++) a[i] = axis_reg[3 + i];
      p = a[0] * d[0] + a[1] * d[1] + a[2] * d[2];
      c[0] = d[1] * a[2] - d[2] * a[1];
      c[1] = d[2] * a[0] - d[0] * a[2];
      c[2] = d[0] * a[1] - d[1] * a[0];
      cx = abs_trunc10(c[0]);
      cy = abs_trunc10(c[1]);
      cz = abs_trunc10(c[2]);
      rr = int_sqrt(cx * cx + cy * cy + cz * cz);
      pr = p >>> 14;
      if (pr > 262143) pr = 262143;
      if (pr < -262144) pr = -262144;
      e.proj = pr[18:0];
      e.rad = ((rr >> 4) > 262143) ? 18'h3ffff : 18'(rr >> 4);
      xs = p + 64'sd2621440;
      if (xs < 0) bx = 0;
      else if (xs >= 64'sd52428800) bx = X_BINS_DEF + 1;
      else bx = 1 + (xs * X_BINS_DEF) / 64'sd52428800;
      if (rr >= 25600) by = Y_BINS_DEF + 1;
      else by = 1 + longint'((rr * Y_BINS_DEF) / 25600);
      w = (rr == 0) ? 64'd65536 : (64'd16777216 / rr);
      idx = int'(bx * NBY + by);
      if (!count_hist.exists(idx)) begin
        count_hist[idx] = 0;
        weight_hist[idx] = 0;
      end
      if (count_hist[idx] != 32'hffff_ffff) count_hist[idx] = count_hist[idx] + 1;
      ws = weight_hist[idx] + w;
      if (ws > 64'hffff_ffff_ffff) ws = 64'hffff_ffff_ffff;
      weight_hist[idx] = ws;
    end
    e.bx = bx[10:0];
    e.by = by[9:0];
    e.cnt = count_hist.exists(idx) ? count_hist[idx] : 32'd0;
    e.wsum = weight_hist.exists(idx) ? weight_hist[idx][47:0] : 48'd0;
    return e;
  endfunction

  // send one request; random gap of idle cycles unless calm
  task automatic send_req(hit_req_t r);
    int gap;
    bit done;
    gap = calm ? 0 : $urandom_range(0, 3);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.command <= r.cmd;
    in_ch.hit_x <= r.hx;
    in_ch.hit_y <= r.hy;
    in_ch.hit_z <= r.hz;
    in_ch.read_bin_x <= r.rbx;
    in_ch.read_bin_y <= r.rby;
    done = 1'b0;
    while (!done) begin
      @(posedge clk);
      if (in_ch.ready) begin
        done = 1'b1;
        pending_q.push_back(predict_bin(r));
      end
    end
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain();
    idle_input();
    wait (pending_q.size() == 0);
  endtask

  function automatic hit_req_t fill_req(longint x, longint y, longint z);
    hit_req_t r;
    r.cmd = 1'b0;
    r.hx = x[16:0];
    r.hy = y[16:0];
    r.hz = z[16:0];
    r.rbx = 11'($urandom);
    r.rby = 10'($urandom);
    return r;
  endfunction

  function automatic hit_req_t read_req(logic [10:0] bx, logic [9:0] by);
    hit_req_t r;
    r.cmd = 1'b1;
    r.hx = 17'($urandom);
    r.hy = 17'($urandom);
    r.hz = 17'($urandom);
    r.rbx = bx;
    r.rby = by;
    return r;
  endfunction

  // write all six axis registers while the block is idle
  task automatic set_axis(longint vx, longint vy, longint vz,
                          longint ax, longint ay, longint az);
    longint v[6];
    logic [CFG_DW-1:0] wd;
    v = '{vx, vy, vz, ax, ay, az};
    drain();
    for (int i = 0; i < 6; i++) begin
      wd = v[i][16:0];
      if (i >= REG_DIR_X) begin
        wd[16] = $urandom_range(0, 1);
        axis_reg[i] = longint'(signed'(wd[15:0]));
      end else begin
        axis_reg[i] = longint'(signed'(wd));
      end
      @(negedge clk);
      cfg_we <= 1'b1;
      cfg_index <= i[CFG_IW-1:0];
      cfg_wdata <= wd;
    end
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic longint rand_dir();
    case ($urandom_range(0, 3))
      0: return 16384;
      1: return -16384;
      default: return longint'($urandom_range(0, 32768)) - 16384;
    endcase
  endfunction

  // receiver ready: per-result stall, long hold-off when requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (rx_stall > 0) begin
      out_ch.ready <= 1'b0;
      rx_stall <= rx_stall - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    bin_result_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      rx_stall <= calm ? 0 : $urandom_range(0, 3);
      if (pending_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result bin %0d/%0d", out_ch.bin_x, out_ch.bin_y);
      end else begin
        e = pending_q.pop_front();
        if (out_ch.projection !== e.proj || out_ch.radius !== e.rad ||
            out_ch.bin_x !== e.bx || out_ch.bin_y !== e.by ||
            out_ch.bin_count !== e.cnt || out_ch.bin_weight_sum !== e.wsum) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("mismatch exp p=%0d r=%0d b=%0d/%0d c=%0d w=%0d got p=%0d r=%0d b=%0d/%0d c=%0d w=%0d",
                     e.proj, e.rad, e.bx, e.by, e.cnt, e.wsum,
                     out_ch.projection, out_ch.radius, out_ch.bin_x, out_ch.bin_y,
                     out_ch.bin_count, out_ch.bin_weight_sum);
        end
      end
    end
  end

  // empty bins after reset, hit on the vertex, read it back
  task automatic test_reset_state();
    send_req(read_req(11'd0, 10'd0));
    send_req(read_req(11'd2001, 10'd1001));
    send_req(fill_req(0, 0, 0));
    send_req(fill_req(0, 0, 0));
    send_req(read_req(11'd101, 10'd1));
    send_req(fill_req(160, 16, -16));
  endtask

  // field extremes, clamping, underflow and overflow bins, reads past overflow
  task automatic test_extremes();
    send_req(fill_req(65535, 65535, 65535));
    send_req(fill_req(-65536, -65536, -65536));
    send_req(fill_req(-65536, 65535, 0));
    send_req(read_req(11'h7ff, 10'h3ff));
    send_req(read_req(11'd2001, 10'h3ff));
    send_req(read_req(11'h7ff, 10'd0));
    set_axis(-65536, 65535, -65536, 16384, 16384, 16384);
    send_req(fill_req(65535, -65536, 65535));
    send_req(fill_req(65535, 65535, 65535));
    send_req(fill_req(-65536, -65536, -65536));
    set_axis(65535, -65536, 0, -16384, 0, -16384);
    send_req(fill_req(65535, -65536, 0));
    send_req(fill_req(-65536, 65535, 65535));
    set_axis(0, 0, 0, 0, 16384, 0);
    send_req(fill_req(5, 3199, 0));
    send_req(fill_req(0, -161, 1600));
    send_req(fill_req(0, 2960, 1599));
    send_req(read_req(last_bx, last_by));
  endtask

  // receiver holds off while requests keep coming, then a full pause
  task automatic test_backpressure();
    drain();
    calm = 1'b1;
    hold_cycles = 600;
    for (int i = 0; i < 12; i++)
      send_req(($urandom_range(0, 1)) ? fill_req(i * 8, 40, 0) : read_req(11'd1, 10'd1));
    calm = 1'b0;
    drain();
  endtask

  // random traffic under a handful of axis settings
  task automatic test_random(int n);
    hit_req_t r;
    bin_result_t pk;
    longint sx, sy, sz;
    for (int i = 0; i < n; i++) begin
      if (i % 400 == 0)
        set_axis(longint'($urandom_range(0, 131071)) - 65536,
                 longint'($urandom_range(0, 131071)) - 65536,
                 longint'($urandom_range(0, 131071)) - 65536,
                 rand_dir(), rand_dir(), rand_dir());
      if (i % 400 == 200) calm = ~calm;
      if (i == n / 2) test_backpressure();
      case ($urandom_range(0, 9))
        0, 1: begin
          if ($urandom_range(0, 1)) r = read_req(11'($urandom), 10'($urandom));
          else if (pending_q.size() > 0) begin
            pk = pending_q[$];
            r = read_req(pk.bx, pk.by);
          end else r = read_req(last_bx, last_by);
        end
        2: r = fill_req(longint'($urandom_range(0, 131071)) - 65536,
                        longint'($urandom_range(0, 131071)) - 65536,
                        longint'($urandom_range(0, 131071)) - 65536);
        3: r = fill_req(sx, sy, sz);
        default: begin
          // hits near the vertex land inside the histogram
          sx = axis_reg[0] + longint'($urandom_range(0, 6400)) - 1600;
          sy = axis_reg[1] + longint'($urandom_range(0, 3200)) - 1600;
          sz = axis_reg[2] + longint'($urandom_range(0, 3200)) - 1600;
          r = fill_req(sx, sy, sz);
        end
      endcase
      send_req(r);
      if (pending_q.size() > 0) begin
        last_bx = pending_q[$].bx;
        last_by = pending_q[$].by;
      end
    end
  endtask

  initial begin
    axis_reg = '{0, 0, 0, 16384, 0, 0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_extremes();
    test_backpressure();
    test_random(2000);
    drain();
    repeat (150) @(posedge clk);
    if (err_cnt == 0 && pending_q.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit: covers the clearing sweep after reset plus all requests
  initial begin
    #(8 * 12_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
